// ===== hw/rtl/note_priority_stack_assert.svh =====
// Assertion macros for the note priority stack checker.
`ifndef NOTE_PRIORITY_STACK_ASSERT_SVH
`define NOTE_PRIORITY_STACK_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define NPS_ASSERT_SAME(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define NPS_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ===== hw/rtl/nps_pkg.sv =====
// Shared types and constants of the note priority stack.
`timescale 1ns / 1ps
package nps_pkg;

  localparam int NOTE_W = 7;
  localparam int VEL_W = 7;
  localparam int REQ_W = 4;
  localparam int OP_W = 2;
  localparam int DEFAULT_STACK_SIZE = 8;

  localparam logic [OP_W-1:0] OP_PUSH = 2'd0;
  localparam logic [OP_W-1:0] OP_REMOVE = 2'd1;
  localparam logic [OP_W-1:0] OP_PEEK = 2'd2;

  typedef enum logic {
    ST_IDLE,
    ST_PEEK
  } state_t;

  typedef struct packed {
    logic load_new;
    logic shift;
    logic set_vel;
  } cell_ctrl_t;

endpackage

// ===== hw/rtl/nps_cell.sv =====
// One entry of the note row: holds a note and velocity and compares against the key.
`timescale 1ns / 1ps
module nps_cell (
  input  logic                             clk,
  input  nps_pkg::cell_ctrl_t              ctrl,
  input  logic                             occupied,
  input  logic [nps_pkg::NOTE_W-1:0]       key,
  input  logic [nps_pkg::VEL_W-1:0]        new_vel,
  input  logic [nps_pkg::NOTE_W-1:0]       nbr_note,
  input  logic [nps_pkg::VEL_W-1:0]        nbr_vel,
  output logic                             hit,
  output logic [nps_pkg::NOTE_W-1:0]       note_q,
  output logic [nps_pkg::VEL_W-1:0]        vel_q
);

  logic [nps_pkg::NOTE_W-1:0] stored_note;
  logic [nps_pkg::VEL_W-1:0]  stored_vel;

  always_ff @(posedge clk) begin
    priority if (ctrl.load_new) begin
      stored_note <= key;
      stored_vel  <= new_vel;
    end else if (ctrl.shift) begin
      stored_note <= nbr_note;
      stored_vel  <= nbr_vel;
    end else if (ctrl.set_vel) begin
      stored_vel <= new_vel;
    end else begin
      stored_note <= stored_note;
      stored_vel  <= stored_vel;
    end
  end

  assign hit    = occupied && (stored_note == key);
  assign note_q = stored_note;
  assign vel_q  = stored_vel;

endmodule

// ===== hw/rtl/note_priority_stack.sv =====
// Top level of the note priority stack: a row of entry cells plus command control.
`timescale 1ns / 1ps
// Push and remove: the command is accepted when start is high and busy is low,
// the row of cells updates at that edge, and the single result beat appears on
// the next cycle; a peek that returns no entries also gives one such beat. A peek
// that returns entries keeps busy high while it streams them oldest to newest,
// one beat per cycle with last on the final beat; each entry is read in the peek
// state through the row's read select, which sets that pace, and then registered.
// Every result beat is shown for exactly one cycle with strobe high and cannot be
// held off, so the receiver must take each beat when it appears.
module note_priority_stack #(
  parameter int STACK_SIZE = nps_pkg::DEFAULT_STACK_SIZE
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  output logic                          busy,
  input  logic [nps_pkg::OP_W-1:0]      op,
  input  logic [nps_pkg::NOTE_W-1:0]    note,
  input  logic [nps_pkg::VEL_W-1:0]     velocity,
  input  logic [nps_pkg::REQ_W-1:0]     count_requested,
  output logic                          strobe,
  output logic                          ok,
  output logic                          entry_valid,
  output logic [nps_pkg::NOTE_W-1:0]    out_note,
  output logic [nps_pkg::VEL_W-1:0]     out_velocity,
  output logic                          last
);

  localparam int FW = $clog2(STACK_SIZE + 1);
  localparam int IW = $clog2(STACK_SIZE);
  localparam int CW = (FW > nps_pkg::REQ_W) ? FW : nps_pkg::REQ_W;

  nps_pkg::state_t state, state_next;

  logic [FW-1:0] fill, fill_next;
  logic [IW-1:0] idx, idx_next;
  logic [FW-1:0] remain, remain_next;

  logic                       strobe_next, ok_next, entry_valid_next, last_next;
  logic [nps_pkg::NOTE_W-1:0] out_note_next;
  logic [nps_pkg::VEL_W-1:0]  out_velocity_next;

  logic [STACK_SIZE-1:0] hit;
  logic [STACK_SIZE-1:0] hit_upto;
  logic [nps_pkg::NOTE_W-1:0] cell_note [STACK_SIZE];
  logic [nps_pkg::VEL_W-1:0]  cell_vel [STACK_SIZE];

  logic          accept, found, full, peek_go;
  logic [CW-1:0] req_w, fill_w, cnt_w;
  logic [FW-1:0] cnt;
  logic [FW-1:0] start_pos;

  assign accept  = start && !busy;
  assign found   = |hit;
  assign full    = (fill == FW'(STACK_SIZE));
  assign req_w   = CW'(count_requested);
  assign fill_w  = CW'(fill);
  assign cnt_w   = (req_w >= fill_w) ? fill_w : req_w;
  assign cnt     = FW'(cnt_w);
  assign start_pos = fill - cnt;
  assign peek_go = (count_requested != '0) && (fill != '0);

  assign hit_upto[0] = hit[0];

  for (genvar i = 0; i < STACK_SIZE; i++) begin : g_row
    logic [nps_pkg::NOTE_W-1:0] nbr_note;
    logic [nps_pkg::VEL_W-1:0]  nbr_vel;
    nps_pkg::cell_ctrl_t        ctrl;

    if (i > 0) begin : g_pre
      assign hit_upto[i] = hit_upto[i-1] | hit[i];
    end

    if (i < STACK_SIZE - 1) begin : g_nbr
      assign nbr_note = cell_note[i+1];
      assign nbr_vel  = cell_vel[i+1];
    end else begin : g_end
      assign nbr_note = cell_note[i];
      assign nbr_vel  = cell_vel[i];
    end

    always_comb begin
      ctrl = '0;
      if (accept) begin
        unique case (op)
          nps_pkg::OP_PUSH: begin
            if (found) begin
              ctrl.set_vel = hit[i];
            end else if (full) begin
              ctrl.shift    = (i < STACK_SIZE - 1);
              ctrl.load_new = (i == STACK_SIZE - 1);
            end else begin
              ctrl.load_new = (fill == FW'(i));
            end
          end
          nps_pkg::OP_REMOVE: begin
            ctrl.shift = found && hit_upto[i] && (i < STACK_SIZE - 1);
          end
          default: begin
            ctrl = '0;
          end
        endcase
      end
    end

    nps_cell u_cell (
      .clk      (clk),
      .ctrl     (ctrl),
      .occupied (FW'(i) < fill),
      .key      (note),
      .new_vel  (velocity),
      .nbr_note (nbr_note),
      .nbr_vel  (nbr_vel),
      .hit      (hit[i]),
      .note_q   (cell_note[i]),
      .vel_q    (cell_vel[i])
    );
  end

  always_comb begin
    state_next = state;
    unique case (state)
      nps_pkg::ST_IDLE: begin
        if (accept && (op == nps_pkg::OP_PEEK) && peek_go) begin
          state_next = nps_pkg::ST_PEEK;
        end
      end
      nps_pkg::ST_PEEK: begin
        if (remain == FW'(1)) begin
          state_next = nps_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = nps_pkg::ST_IDLE;
      end
    endcase
  end

  always_comb begin
    busy = (state == nps_pkg::ST_PEEK);
  end

  always_comb begin
    strobe_next       = 1'b0;
    ok_next           = 1'b0;
    entry_valid_next  = 1'b0;
    out_note_next     = '0;
    out_velocity_next = '0;
    last_next         = 1'b1;
    fill_next         = fill;
    idx_next          = idx;
    remain_next       = remain;
    if (state == nps_pkg::ST_PEEK) begin
      strobe_next       = 1'b1;
      ok_next           = 1'b1;
      entry_valid_next  = 1'b1;
      out_note_next     = cell_note[idx];
      out_velocity_next = cell_vel[idx];
      last_next         = (remain == FW'(1));
      idx_next          = idx + 1'b1;
      remain_next       = remain - 1'b1;
    end else if (accept) begin
      strobe_next = 1'b1;
      unique case (op)
        nps_pkg::OP_PUSH: begin
          ok_next = 1'b1;
          if (!found && !full) begin
            fill_next = fill + 1'b1;
          end
        end
        nps_pkg::OP_REMOVE: begin
          ok_next = found;
          if (found) begin
            fill_next = fill - 1'b1;
          end
        end
        nps_pkg::OP_PEEK: begin
          if (peek_go) begin
            strobe_next = 1'b0;
            idx_next    = IW'(start_pos);
            remain_next = cnt;
          end
        end
        default: begin
          ok_next = 1'b0;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= nps_pkg::ST_IDLE;
      fill   <= '0;
      strobe <= 1'b0;
    end else begin
      state  <= state_next;
      fill   <= fill_next;
      strobe <= strobe_next;
    end
  end

  always_ff @(posedge clk) begin
    idx          <= idx_next;
    remain       <= remain_next;
    ok           <= ok_next;
    entry_valid  <= entry_valid_next;
    out_note     <= out_note_next;
    out_velocity <= out_velocity_next;
    last         <= last_next;
  end

endmodule

// ===== hw/rtl/nps_checker.sv =====
// Port-level checker for the note priority stack, bound to the top level.
`timescale 1ns / 1ps
`include "note_priority_stack_assert.svh"
module nps_checker (
  input logic                          clk,
  input logic                          rst,
  input logic                          start,
  input logic                          busy,
  input logic [nps_pkg::OP_W-1:0]      op,
  input logic                          strobe,
  input logic                          ok,
  input logic                          entry_valid,
  input logic [nps_pkg::NOTE_W-1:0]    out_note,
  input logic [nps_pkg::VEL_W-1:0]     out_velocity,
  input logic                          last
);

  logic cmd_beat;
  logic single_cmd;
  logic empty_payload;

  assign cmd_beat      = start && !busy;
  assign single_cmd    = cmd_beat && (op != nps_pkg::OP_PEEK);
  assign empty_payload = (out_note == '0) && (out_velocity == '0);

  `NPS_ASSERT_NEXT(a_single_result, clk, rst, single_cmd, strobe && last && !entry_valid, "push or remove gave no single result beat")
  `NPS_ASSERT_NEXT(a_stream_continues, clk, rst, strobe && !last, strobe && entry_valid, "peek stream broke before its last beat")
  `NPS_ASSERT_SAME(a_entry_ok, clk, rst, strobe && entry_valid, ok && ($past(busy) || $past(cmd_beat)), "entry beat without success or without a command")
  `NPS_ASSERT_SAME(a_status_clean, clk, rst, strobe && !entry_valid, last && empty_payload, "status beat carries entry data or lacks last")

endmodule

bind note_priority_stack nps_checker u_nps_checker (.*);
